>>> hw/rtl/lkvc_pkg.sv
// Shared constants, payload types, the controller state type and the command
// bundle for the LRU key-value cache. No dependencies.
package lkvc_pkg;

    localparam int ENTRIES    = 16;
    localparam int KEY_BITS   = 16;
    localparam int VALUE_BITS = 32;
    localparam int CAP_W      = 5;
    localparam int IDX_W      = $clog2(ENTRIES);
    localparam int CNT_W      = $clog2(ENTRIES + 1);

    localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(16);

    localparam logic MODE_GET = 1'b0;
    localparam logic MODE_PUT = 1'b1;

    typedef logic        [KEY_BITS-1:0]   t_key;
    typedef logic signed [VALUE_BITS-1:0] t_value;
    typedef logic        [CAP_W-1:0]      t_cap;
    typedef logic        [IDX_W-1:0]      t_idx;
    typedef logic        [CNT_W-1:0]      t_cnt;

    typedef enum logic [2:0] {
        S_IDLE   = 3'b001,
        S_MATCH  = 3'b010,
        S_UPDATE = 3'b100
    } t_state;

    typedef struct packed {
        logic load_req;
        logic match;
        logic commit;
    } t_cmd;

endpackage

>>> hw/rtl/lkvc_ifs.sv
// Channel interfaces of the LRU key-value cache: request, response and
// capacity write. Depends on lkvc_pkg.
interface lkvc_req_if;
    logic              valid;
    logic              ready;
    logic              mode;
    lkvc_pkg::t_key    key;
    lkvc_pkg::t_value  value;
    modport source (output valid, output mode, output key, output value, input ready);
    modport sink   (input valid, input mode, input key, input value, output ready);
endinterface

interface lkvc_rsp_if;
    logic              valid;
    logic              ready;
    logic              found;
    lkvc_pkg::t_value  read_value;
    logic              evicted;
    lkvc_pkg::t_key    evicted_key;
    modport source (output valid, output found, output read_value, output evicted,
                    output evicted_key, input ready);
    modport sink   (input valid, input found, input read_value, input evicted,
                    input evicted_key, output ready);
endinterface

interface lkvc_cfg_if;
    logic              valid;
    logic              ready;
    lkvc_pkg::t_cap    capacity;
    modport source (output valid, output capacity, input ready);
    modport sink   (input valid, input capacity, output ready);
endinterface

>>> hw/rtl/lru_key_value_cache_top.sv
// Top level of the LRU key-value cache: controller plus datapath behind
// valid/ready channels. Depends on lkvc_pkg, lkvc_ifs, lkvc_ctrl, lkvc_dp.
//
// Fully associative store of up to 16 key/value entries with least-recently-
// used replacement. Each request beat is a get (mode 0) or a put (mode 1).
// Every request yields exactly one response beat: found tells whether the key
// was present, read_value carries the stored value on a get hit (zero
// otherwise), and evicted/evicted_key report the least recent entry that a put
// of a new key pushed out when the store was at capacity. A new key fills the
// lowest free slot, or the evicted entry's slot when full. A request passes
// through a match step, which compares the key against all entries and locates
// the least recent and the lowest free slot, and an update step, which updates
// the per-entry recency ranks, the store and the response register. A new
// request is accepted in the update cycle of the previous one, as that one
// commits; the update waits while an earlier response beat has not been taken.
// The capacity register (1 to 16, resets to 16; zero acts as 1, larger values
// as 16) is always ready, but a write takes effect only while the store is
// empty. Reset clears the valid bits, ranks and occupancy.
module lru_key_value_cache_top (
    input logic i_clk,
    input logic i_rst_n,
    lkvc_req_if.sink   i_req,
    lkvc_rsp_if.source o_rsp,
    lkvc_cfg_if.sink   i_cfg
);
    import lkvc_pkg::*;

    t_cmd cmd;
    logic req_ready;
    logic rsp_valid;

    lkvc_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req.valid),
        .o_req_ready (req_ready),
        .o_rsp_valid (rsp_valid),
        .i_rsp_ready (o_rsp.ready),
        .o_cmd       (cmd)
    );

    lkvc_dp u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .i_mode        (i_req.mode),
        .i_key         (i_req.key),
        .i_value       (i_req.value),
        .i_cfg_we      (i_cfg.valid),
        .i_cfg_cap     (i_cfg.capacity),
        .o_found       (o_rsp.found),
        .o_read_value  (o_rsp.read_value),
        .o_evicted     (o_rsp.evicted),
        .o_evicted_key (o_rsp.evicted_key)
    );

    assign i_req.ready = req_ready;
    assign o_rsp.valid = rsp_valid;
    assign i_cfg.ready = 1'b1;

endmodule

>>> hw/rtl/lkvc_ctrl.sv
// Controller of the LRU key-value cache: request/response handshakes and the
// idle, match and update sequence. Depends on lkvc_pkg.
module lkvc_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_req_valid,
    output logic           o_req_ready,
    output logic           o_rsp_valid,
    input  logic           i_rsp_ready,
    output lkvc_pkg::t_cmd o_cmd
);
    import lkvc_pkg::*;

    t_state r_state, n_state;
    logic   r_rsp_valid, n_rsp_valid;
    logic   commit;
    logic   accept;

    // The update may only commit when the response register can take a beat.
    assign commit      = (r_state == S_UPDATE) && (!r_rsp_valid || i_rsp_ready);
    assign o_req_ready = (r_state == S_IDLE) || commit;
    assign accept      = i_req_valid && o_req_ready;

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (accept) n_state = S_MATCH;
            end
            S_MATCH: begin
                n_state = S_UPDATE;
            end
            S_UPDATE: begin
                if (commit) n_state = accept ? S_MATCH : S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        n_rsp_valid = r_rsp_valid;
        if (commit) n_rsp_valid = 1'b1;
        else if (i_rsp_ready) n_rsp_valid = 1'b0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_rsp_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_rsp_valid <= n_rsp_valid;
        end
    end

    assign o_rsp_valid     = r_rsp_valid;
    assign o_cmd.load_req  = accept;
    assign o_cmd.match     = (r_state == S_MATCH);
    assign o_cmd.commit    = commit;

`ifndef ASSERT_OFF
    a_accept_to_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> (r_state == S_MATCH))
        else $error("accepted request did not enter the match cycle");
    a_commit_shows_rsp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        commit |=> r_rsp_valid)
        else $error("committed update did not present a response");
`endif

endmodule

>>> hw/rtl/lkvc_dp.sv
// Datapath of the LRU key-value cache: entry store, key match, victim and free
// slot search, recency ranks and the response register. Depends on lkvc_pkg.
module lkvc_dp (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  lkvc_pkg::t_cmd   i_cmd,
    input  logic             i_mode,
    input  lkvc_pkg::t_key   i_key,
    input  lkvc_pkg::t_value i_value,
    input  logic             i_cfg_we,
    input  lkvc_pkg::t_cap   i_cfg_cap,
    output logic             o_found,
    output lkvc_pkg::t_value o_read_value,
    output logic             o_evicted,
    output lkvc_pkg::t_key   o_evicted_key
);
    import lkvc_pkg::*;

    // Entry store and recency state.
    t_key               r_keys  [ENTRIES];
    t_value             r_vals  [ENTRIES];
    t_idx               r_rank  [ENTRIES];
    logic [ENTRIES-1:0] r_valid;
    t_cnt               r_occ;
    t_cap               r_cap;

    // Latched request.
    logic   r_mode;
    t_key   r_key;
    t_value r_val;

    // Match cycle results.
    logic r_hit, r_full;
    t_idx r_hit_idx, r_vic_idx, r_free_idx;

    // Response register.
    logic   r_found, r_ev;
    t_value r_rdval;
    t_key   r_evkey;

    t_cnt lim;
    logic m_hit;
    t_idx m_hit_idx, m_vic_idx, m_free_idx;
    logic m_free_any;

    logic do_put, do_evict, do_insert, do_promote;
    t_idx slot;
    t_cnt old_rank;

    always_comb begin
        if (r_cap == '0) lim = CNT_W'(1);
        else if (int'(r_cap) > ENTRIES) lim = CNT_W'(ENTRIES);
        else lim = CNT_W'(r_cap);
    end

    // Parallel key compare, least recent entry and lowest free slot.
    always_comb begin
        m_hit      = 1'b0;
        m_hit_idx  = '0;
        m_vic_idx  = '0;
        m_free_idx = '0;
        m_free_any = 1'b0;
        for (int i = ENTRIES - 1; i >= 0; i--) begin
            if (r_valid[i] && r_keys[i] == r_key) begin
                m_hit     = 1'b1;
                m_hit_idx = IDX_W'(i);
            end
            if (r_valid[i] && CNT_W'(r_rank[i]) == r_occ - CNT_W'(1)) begin
                m_vic_idx = IDX_W'(i);
            end
            if (!r_valid[i]) begin
                m_free_any = 1'b1;
                m_free_idx = IDX_W'(i);
            end
        end
    end

    assign do_put     = (r_mode == MODE_PUT);
    assign do_evict   = do_put && !r_hit && r_full;
    assign do_insert  = do_put && !r_hit && !r_full;
    assign do_promote = r_hit || do_put;

    always_comb begin
        if (r_hit) begin
            slot     = r_hit_idx;
            old_rank = CNT_W'(r_rank[r_hit_idx]);
        end else if (r_full) begin
            slot     = r_vic_idx;
            old_rank = r_occ - CNT_W'(1);
        end else begin
            slot     = r_free_idx;
            old_rank = r_occ;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_req) begin
            r_mode <= i_mode;
            r_key  <= i_key;
            r_val  <= i_value;
        end
        if (i_cmd.match) begin
            r_hit      <= m_hit;
            r_hit_idx  <= m_hit_idx;
            r_vic_idx  <= m_vic_idx;
            r_free_idx <= m_free_idx;
            r_full     <= (r_occ >= lim) || !m_free_any;
        end
        if (i_cmd.commit) begin
            r_found <= r_hit;
            r_rdval <= (r_hit && !do_put) ? r_vals[r_hit_idx] : '0;
            r_ev    <= do_evict;
            r_evkey <= do_evict ? r_keys[r_vic_idx] : '0;
            if (do_put) begin
                r_vals[slot] <= r_val;
                if (!r_hit) r_keys[slot] <= r_key;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
            r_occ   <= '0;
            r_cap   <= CAP_RESET;
            for (int i = 0; i < ENTRIES; i++) r_rank[i] <= '0;
        end else begin
            if (i_cfg_we && r_occ == '0) r_cap <= i_cfg_cap;
            if (i_cmd.commit && do_promote) begin
                for (int i = 0; i < ENTRIES; i++) begin
                    if (IDX_W'(i) == slot) begin
                        r_rank[i] <= '0;
                    end else if (r_valid[i] && CNT_W'(r_rank[i]) < old_rank) begin
                        r_rank[i] <= r_rank[i] + IDX_W'(1);
                    end
                end
                if (do_insert) begin
                    r_valid[slot] <= 1'b1;
                    r_occ         <= r_occ + CNT_W'(1);
                end
            end
        end
    end

    assign o_found       = r_found;
    assign o_read_value  = r_rdval;
    assign o_evicted     = r_ev;
    assign o_evicted_key = r_evkey;

`ifndef ASSERT_OFF
    a_occ_matches_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $countones(r_valid) == int'(r_occ))
        else $error("occupancy differs from the number of valid entries");
    a_occ_within_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_occ <= lim)
        else $error("occupancy exceeds the capacity limit");
`endif

endmodule
